FILE: src/slvg_pkg.sv
// Package with word types, register indexes and the ellipsoid constant table.
package slvg_pkg;

  localparam int TABLE_ROWS = 10;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic [8:0] voxel_x;
    logic [8:0] voxel_y;
    logic [8:0] voxel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [13:0] density;
    logic [26:0]        linear_address;
  } out_word_t;

  // Centers, rotation and intensity in Q2.14 / Q2.12.
  localparam logic signed [15:0] ELL_CX [TABLE_ROWS] =
    '{16'sd0, 16'sd0, 16'sd3604, -16'sd3604, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
  localparam logic signed [15:0] ELL_CY [TABLE_ROWS] =
    '{16'sd0, -16'sd301, 16'sd0, 16'sd0, 16'sd5734, 16'sd1638, -16'sd1638, -16'sd4915,
      16'sd0, 16'sd0};
  localparam logic signed [15:0] ELL_CZ [TABLE_ROWS] =
    '{16'sd0, 16'sd0, -16'sd4096, -16'sd4096, -16'sd4096, -16'sd4096, -16'sd4096,
      -16'sd4096, 16'sd5734, 16'sd5734};
  localparam logic signed [15:0] ELL_COS [TABLE_ROWS] =
    '{16'sd16384, 16'sd16384, -16'sd5063, -16'sd5063, 16'sd16384, 16'sd16384, 16'sd16384,
      16'sd16384, 16'sd16384, 16'sd0};
  localparam logic signed [15:0] ELL_SIN [TABLE_ROWS] =
    '{16'sd0, 16'sd0, 16'sd15582, -16'sd15582, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd16384};
  localparam logic signed [13:0] ELL_GAIN [TABLE_ROWS] =
    '{14'sd4096, -14'sd3277, -14'sd819, -14'sd819, -14'sd819, -14'sd819, -14'sd410,
      -14'sd410, 14'sd410, 14'sd410};

  // Inverse squared semi-axes, round(2^16 / a^2).
  localparam logic [27:0] ELL_INV_X [TABLE_ROWS] =
    '{28'd137652, 28'd149362, 28'd389863, 28'd389863, 28'd1048576, 28'd1238866,
      28'd1354050, 28'd1638400, 28'd2912711, 28'd2912711};
  localparam logic [27:0] ELL_INV_Y [TABLE_ROWS] =
    '{28'd77429, 28'd85794, 28'd2560000, 28'd2560000, 28'd1238866, 28'd26214400,
      28'd163840000, 28'd40960000, 28'd26214400, 28'd26214400};
  localparam logic [27:0] ELL_INV_Z [TABLE_ROWS] =
    '{28'd80909, 28'd84628, 28'd1486077, 28'd1486077, 28'd262144, 28'd1638400,
      28'd1638400, 28'd1638400, 28'd26214400, 28'd26214400};

endpackage

FILE: src/slvg_div.sv
// Pipelined restoring divider that maps one voxel index to a Q2.14 coordinate.
module slvg_div (
  input  logic               clk,
  input  logic [8:0]         vox,
  input  logic [9:0]         dm1,
  output logic signed [15:0] coord
);
  import slvg_pkg::*;

  localparam int QBITS = 16;

  logic [26:0] rem_r [QBITS+1];
  logic [10:0] dd_r  [QBITS+1];
  logic        ovr_r [QBITS+1];
  logic [15:0] q_r   [QBITS+1];
  logic signed [15:0] coord_r;

  logic [26:0] num;
  logic [26:0] top_div;
  logic [10:0] dd_nxt0;

  assign dd_nxt0 = {dm1, 1'b0};
  assign num     = {2'b00, vox, 16'h0000} + 27'(dm1);
  assign top_div = {dd_nxt0, 16'h0000};

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    dd_r[0]  <= dd_nxt0;
    ovr_r[0] <= (num >= top_div);
    q_r[0]   <= 16'h0000;
  end

  genvar j;
  generate
    for (j = 0; j < QBITS; j++) begin : g_stage
      logic [26:0] sh;
      logic        ge;
      assign sh = 27'(dd_r[j]) << (QBITS - 1 - j);
      assign ge = (rem_r[j] >= sh);
      always_ff @(posedge clk) begin
        rem_r[j+1] <= ge ? (rem_r[j] - sh) : rem_r[j];
        dd_r[j+1]  <= dd_r[j];
        ovr_r[j+1] <= ovr_r[j];
        q_r[j+1]   <= {q_r[j][14:0], ge};
      end
    end
  endgenerate

  logic signed [16:0] shifted;
  assign shifted = $signed({1'b0, q_r[QBITS]}) - 17'sd16384;

  always_ff @(posedge clk) begin
    if (ovr_r[QBITS] || (shifted > 17'sd32767)) begin
      coord_r <= 16'sd32767;
    end else begin
      coord_r <= shifted[15:0];
    end
  end

  assign coord = coord_r;

endmodule

FILE: src/slvg_ell.sv
// Five-stage ellipsoid membership test for one fixed ellipsoid of the table.
module slvg_ell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic signed [15:0] xn,
  input  logic signed [15:0] yn,
  input  logic signed [15:0] zn,
  output logic               hit
);
  import slvg_pkg::*;

  localparam logic signed [15:0] CX = ELL_CX[IDX];
  localparam logic signed [15:0] CY = ELL_CY[IDX];
  localparam logic signed [15:0] CZ = ELL_CZ[IDX];
  localparam logic signed [15:0] CS = ELL_COS[IDX];
  localparam logic signed [15:0] SN = ELL_SIN[IDX];
  localparam logic [27:0] IX = ELL_INV_X[IDX];
  localparam logic [27:0] IY = ELL_INV_Y[IDX];
  localparam logic [27:0] IZ = ELL_INV_Z[IDX];

  logic signed [16:0] xt, yt, zt;
  logic signed [32:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [16:0] zt_r, zt2_r;
  logic signed [33:0] sx, sy;
  logic signed [17:0] xr_r, yr_r;
  logic [35:0] xsq, ysq;
  logic [33:0] zsq;
  logic [27:0] xc_r, yc_r, zc_r;
  logic [55:0] mx_r, my_r, mz_r;
  logic [57:0] qsum;
  logic        hit_r;

  assign xt = 17'(xn) - 17'(CX);
  assign yt = 17'(yn) - 17'(CY);
  assign zt = 17'(zn) - 17'(CZ);

  always_ff @(posedge clk) begin
    p1_r <= xt * CS;
    p2_r <= yt * SN;
    p3_r <= yt * CS;
    p4_r <= xt * SN;
    zt_r <= zt;
  end

  assign sx = 34'(p1_r) + 34'(p2_r) + 34'sd8192;
  assign sy = 34'(p3_r) - 34'(p4_r) + 34'sd8192;

  always_ff @(posedge clk) begin
    xr_r  <= 18'(sx >>> 14);
    yr_r  <= 18'(sy >>> 14);
    zt2_r <= zt_r;
  end

  assign xsq = 36'(xr_r) * 36'(xr_r);
  assign ysq = 36'(yr_r) * 36'(yr_r);
  assign zsq = 34'(zt2_r) * 34'(zt2_r);

  always_ff @(posedge clk) begin
    xc_r <= (xsq[35:28] != 8'h00) ? '1 : xsq[27:0];
    yc_r <= (ysq[35:28] != 8'h00) ? '1 : ysq[27:0];
    zc_r <= (zsq[33:28] != 6'h00) ? '1 : zsq[27:0];
  end

  always_ff @(posedge clk) begin
    mx_r <= 56'(xc_r) * 56'(IX);
    my_r <= 56'(yc_r) * 56'(IY);
    mz_r <= 56'(zc_r) * 56'(IZ);
  end

  assign qsum = 58'(mx_r) + 58'(my_r) + 58'(mz_r);

  always_ff @(posedge clk) begin
    hit_r <= (qsum <= (58'd1 << 44));
  end

  assign hit = hit_r;

endmodule

FILE: src/shepp_logan_voxel_generator_core.sv
// Top level of the 3D Shepp-Logan phantom voxel generator.
// An accepted start travels down the valid shift register to the out_valid strobe.
// One word is accepted every cycle; busy stays low and results cannot be stalled.
// The depth is the 18-stage coordinate divider, the five-stage ellipsoid test and two
// stages of summing and saturation.
// Synchronous active-low reset clears the valid pipeline and sets all sizes to 256.
module shepp_logan_voxel_generator_core #(
  parameter int MAX_DIM        = 512,
  parameter int NUM_ELLIPSOIDS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  slvg_pkg::in_word_t  in_word,
  output logic                out_valid,
  output slvg_pkg::out_word_t out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import slvg_pkg::*;

  localparam int LAT      = 25;
  localparam int ADDR_DLY = 22;
  localparam int N_ACT    = (NUM_ELLIPSOIDS < TABLE_ROWS) ? NUM_ELLIPSOIDS : TABLE_ROWS;

  logic [9:0] size_x_r, size_y_r, size_z_r;
  logic       wr_en;
  logic       accept;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 10'd256;
      size_y_r <= 10'd256;
      size_z_r <= 10'd256;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SIZE_X: size_x_r <= pwdata[9:0];
        REG_SIZE_Y: size_y_r <= pwdata[9:0];
        REG_SIZE_Z: size_z_r <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = {22'h0, size_x_r};
      REG_SIZE_Y: prdata = {22'h0, size_y_r};
      REG_SIZE_Z: prdata = {22'h0, size_z_r};
      default:    prdata = 32'h0;
    endcase
  end

  function automatic logic [9:0] eff_size(input logic [9:0] s);
    logic [9:0] r;
    if (s < 10'd2) begin
      r = 10'd2;
    end else if (int'(s) > MAX_DIM) begin
      r = 10'(MAX_DIM);
    end else begin
      r = s;
    end
    return r;
  endfunction

  logic [9:0] sx, sy, sz;
  assign sx = eff_size(size_x_r);
  assign sy = eff_size(size_y_r);
  assign sz = eff_size(size_z_r);

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  logic signed [15:0] xn, yn, zn;

  slvg_div u_div_x (.clk(clk), .vox(in_word.voxel_x), .dm1(sx - 10'd1), .coord(xn));
  slvg_div u_div_y (.clk(clk), .vox(in_word.voxel_y), .dm1(sy - 10'd1), .coord(yn));
  slvg_div u_div_z (.clk(clk), .vox(in_word.voxel_z), .dm1(sz - 10'd1), .coord(zn));

  logic [N_ACT-1:0] hits;

  genvar i;
  generate
    for (i = 0; i < N_ACT; i++) begin : g_ell
      slvg_ell #(.IDX(i)) u_ell (
        .clk(clk), .xn(xn), .yn(yn), .zn(zn), .hit(hits[i])
      );
    end
  endgenerate

  logic signed [15:0] sum_nxt, sum_r;
  logic signed [13:0] dens_r;

  always_comb begin
    sum_nxt = 16'sd0;
    for (int k = 0; k < N_ACT; k++) begin
      if (hits[k]) begin
        sum_nxt = sum_nxt + 16'(ELL_GAIN[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (sum_r > 16'sd8191) begin
      dens_r <= 14'sd8191;
    end else if (sum_r < -16'sd8192) begin
      dens_r <= -14'sd8192;
    end else begin
      dens_r <= sum_r[13:0];
    end
  end

  logic [18:0] zx_r, yx_r;
  logic [8:0]  x1_r;
  logic [26:0] zxy_r, addr_r;
  logic [19:0] yxx_r;
  logic [28:0] zxy_full;
  logic [26:0] addr_dly_r [ADDR_DLY];

  assign zxy_full = 29'(zx_r) * 29'(sy);

  always_ff @(posedge clk) begin
    zx_r   <= 19'(in_word.voxel_z) * 19'(sx);
    yx_r   <= 19'(in_word.voxel_y) * 19'(sx);
    x1_r   <= in_word.voxel_x;
    zxy_r  <= zxy_full[26:0];
    yxx_r  <= 20'(yx_r) + 20'(x1_r);
    addr_r <= zxy_r + 27'(yxx_r);
    addr_dly_r[0] <= addr_r;
    for (int k = 1; k < ADDR_DLY; k++) begin
      addr_dly_r[k] <= addr_dly_r[k-1];
    end
  end

  assign out_valid               = vld_r[LAT-1];
  assign out_word.density        = dens_r;
  assign out_word.linear_address = addr_dly_r[ADDR_DLY-1];

  a_out_has_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result word without a start");

  a_size_x_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (paddr[3:2] == REG_SIZE_X)) |=> (size_x_r == $past(pwdata[9:0])))
    else $error("size_x write lost");

  a_size_z_write: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (paddr[3:2] == REG_SIZE_Z)) |=> (size_z_r == $past(pwdata[9:0])))
    else $error("size_z write lost");

endmodule
